// ===== design/u2a_pkg.sv =====
// shared types, codes and digit helpers for the number to ascii formatter
package u2a_pkg;

  localparam int ValueW    = 64;
  localparam int ModeW     = 3;
  localparam int CharW     = 8;
  localparam int CountW    = 5;
  localparam int Dec32Bits = 32;
  localparam int DecDigits = 10;
  localparam int BcdW      = 4 * DecDigits;
  localparam int Hex32Digs = 8;
  localparam int Hex64Digs = 16;
  localparam int MaxChars  = 18;

  localparam logic [ModeW-1:0] MODE_DEC     = 3'd0;
  localparam logic [ModeW-1:0] MODE_HEX32_L = 3'd1;
  localparam logic [ModeW-1:0] MODE_HEX32_U = 3'd2;
  localparam logic [ModeW-1:0] MODE_HEX64_L = 3'd3;
  localparam logic [ModeW-1:0] MODE_HEX64_U = 3'd4;
  localparam logic [ModeW-1:0] MODE_PTR     = 3'd5;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [ModeW-1:0]  mode;
  } u2a_in_t;

  typedef struct packed {
    logic [CharW-1:0]  char_out;
    logic              last;
    logic [CountW-1:0] char_count;
  } u2a_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_PREFIX0,
    ST_PREFIXX,
    ST_EMIT
  } u2a_state_t;

  // one digit value to its ascii code
  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CharW-1:0] base;
    begin
      if (d < 4'd10) begin
        digit_char = ChZero + {4'b0, d};
      end else begin
        base = upper ? ChUpA : ChLowA;
        digit_char = base + {4'b0, d} - 8'd10;
      end
    end
  endfunction

  // add three to every bcd digit of five or more, ahead of the next shift
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] b);
    logic [3:0] nib;
    begin
      bcd_adjust = b;
      for (int i = 0; i < DecDigits; i++) begin
        nib = b[4*i +: 4];
        if (nib >= 4'd5) bcd_adjust[4*i +: 4] = nib + 4'd3;
      end
    end
  endfunction

endpackage

// ===== design/unsigned_number_to_ascii.sv =====
// unsigned number to ascii formatter: decimal and hex, one character per strobe
//
// usage
//   input: a beat is taken at the rising edge where start is high and busy is
//   low; req carries the 64-bit value and the 3-bit mode. modes 6 and 7 are
//   taken but produce no characters.
//   output: each character is shown on result for one cycle with strobe high;
//   the last character of a value has result.last set and result.char_count
//   holding the number of characters sent for that value. the receiver cannot
//   stall the block, so results never wait.
// timing
//   hex modes: the first digit is found and each leading zero digit is
//   dropped, then the characters are sent one by one (after the "0x" of
//   pointer form), so for each mode busy lasts as long whatever the value.
//   decimal: bit-serial binary to bcd conversion of the low 32 bits (shift
//   and add three over ten digits), then the same skip and send over ten
//   digits, so busy too lasts as long whatever the value. each character
//   shows in the cycle after the one that makes it; busy drops as the last
//   character shows, so the next beat may be taken at the edge that takes
//   the last character.
// reset
//   synchronous active-high rst returns the control to idle and drops strobe;
//   the digit registers carry no reset.
module unsigned_number_to_ascii (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  u2a_pkg::u2a_in_t  req,
  output logic              strobe,
  output u2a_pkg::u2a_out_t result
);

  u2a_pkg::u2a_state_t state, state_next;

  // digit shifter: in skip and emit, top nibble is the next character to send
  logic [u2a_pkg::ValueW-1:0] digits, digits_next;
  // bcd accumulator for decimal conversion
  logic [u2a_pkg::BcdW-1:0]   bcd, bcd_next;
  logic [4:0]                 bitcnt, bitcnt_next;
  // digits still held in the shifter
  logic [4:0]                 ndig, ndig_next;
  // characters already sent for this value
  logic [u2a_pkg::CountW-1:0] cnt, cnt_next;
  logic                       upper, upper_next;
  logic                       ptr, ptr_next;
  logic                       strobe_next;
  u2a_pkg::u2a_out_t          result_next;

  logic [u2a_pkg::BcdW-1:0]   bcd_adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= u2a_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    digits <= digits_next;
    bcd    <= bcd_next;
    bitcnt <= bitcnt_next;
    ndig   <= ndig_next;
    cnt    <= cnt_next;
    upper  <= upper_next;
    ptr    <= ptr_next;
    result <= result_next;
  end

  assign busy    = (state != u2a_pkg::ST_IDLE);
  assign bcd_adj = u2a_pkg::bcd_adjust(bcd);

  always_comb begin
    state_next  = state;
    digits_next = digits;
    bcd_next    = bcd;
    bitcnt_next = bitcnt;
    ndig_next   = ndig;
    cnt_next    = cnt;
    upper_next  = upper;
    ptr_next    = ptr;
    strobe_next = 1'b0;
    result_next = result;

    case (state)
      u2a_pkg::ST_IDLE: begin
        if (start) begin
          cnt_next    = '0;
          bcd_next    = '0;
          bitcnt_next = '0;
          ptr_next    = 1'b0;
          upper_next  = 1'b0;
          case (req.mode)
            u2a_pkg::MODE_DEC: begin
              digits_next = {32'b0, req.value[u2a_pkg::Dec32Bits-1:0]};
              state_next  = u2a_pkg::ST_CONVERT;
            end
            u2a_pkg::MODE_HEX32_L, u2a_pkg::MODE_HEX32_U: begin
              digits_next = {req.value[u2a_pkg::Dec32Bits-1:0], 32'b0};
              ndig_next   = 5'(u2a_pkg::Hex32Digs);
              upper_next  = (req.mode == u2a_pkg::MODE_HEX32_U);
              state_next  = u2a_pkg::ST_SKIP;
            end
            u2a_pkg::MODE_HEX64_L, u2a_pkg::MODE_HEX64_U, u2a_pkg::MODE_PTR: begin
              digits_next = req.value;
              ndig_next   = 5'(u2a_pkg::Hex64Digs);
              upper_next  = (req.mode == u2a_pkg::MODE_HEX64_U);
              ptr_next    = (req.mode == u2a_pkg::MODE_PTR);
              state_next  = u2a_pkg::ST_SKIP;
            end
            default: begin
              // undefined modes send nothing
              state_next = u2a_pkg::ST_IDLE;
            end
          endcase
        end
      end

      u2a_pkg::ST_CONVERT: begin
        // double dabble, one binary bit per cycle from the msb
        bcd_next    = {bcd_adj[u2a_pkg::BcdW-2:0], digits[u2a_pkg::Dec32Bits-1]};
        digits_next = {digits[u2a_pkg::ValueW-2:0], 1'b0};
        bitcnt_next = bitcnt + 5'd1;
        if (bitcnt == 5'(u2a_pkg::Dec32Bits - 1)) begin
          digits_next = {bcd_next, 24'b0};
          ndig_next   = 5'(u2a_pkg::DecDigits);
          state_next  = u2a_pkg::ST_SKIP;
        end
      end

      u2a_pkg::ST_SKIP: begin
        // drop leading zero digits, keeping at least one
        if (digits[u2a_pkg::ValueW-1 -: 4] == 4'd0 && ndig > 5'd1) begin
          digits_next = {digits[u2a_pkg::ValueW-5:0], 4'b0};
          ndig_next   = ndig - 5'd1;
        end else if (ptr) begin
          state_next = u2a_pkg::ST_PREFIX0;
        end else begin
          state_next = u2a_pkg::ST_EMIT;
        end
      end

      u2a_pkg::ST_PREFIX0: begin
        strobe_next            = 1'b1;
        result_next.char_out   = u2a_pkg::ChZero;
        result_next.last       = 1'b0;
        result_next.char_count = '0;
        cnt_next               = cnt + 5'd1;
        state_next             = u2a_pkg::ST_PREFIXX;
      end

      u2a_pkg::ST_PREFIXX: begin
        strobe_next            = 1'b1;
        result_next.char_out   = u2a_pkg::ChLowX;
        result_next.last       = 1'b0;
        result_next.char_count = '0;
        cnt_next               = cnt + 5'd1;
        state_next             = u2a_pkg::ST_EMIT;
      end

      u2a_pkg::ST_EMIT: begin
        strobe_next            = 1'b1;
        result_next.char_out   = u2a_pkg::digit_char(digits[u2a_pkg::ValueW-1 -: 4], upper);
        result_next.last       = (ndig == 5'd1);
        result_next.char_count = (ndig == 5'd1) ? cnt + 5'd1 : '0;
        cnt_next               = cnt + 5'd1;
        digits_next            = {digits[u2a_pkg::ValueW-5:0], 4'b0};
        ndig_next              = ndig - 5'd1;
        if (ndig == 5'd1) state_next = u2a_pkg::ST_IDLE;
      end

      default: begin
        state_next = u2a_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // every character comes out of a busy period
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("character sent while idle");

  // the closing character reports a sane count
  a_last_count: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |->
      result.char_count != 5'd0 && result.char_count <= 5'(u2a_pkg::MaxChars))
    else $error("bad character count on last beat");

  // inner characters carry no count
  a_inner_count: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> result.char_count == 5'd0)
    else $error("count on a non-final character");

  // emission never runs out of digits
  a_emit_digits: assert property (@(posedge clk) disable iff (rst)
    state == u2a_pkg::ST_EMIT |-> ndig != 5'd0)
    else $error("emit with no digit left");

  // leaving emission for idle always comes with a closing character
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $past(state) == u2a_pkg::ST_EMIT && state == u2a_pkg::ST_IDLE |-> strobe && result.last)
    else $error("item ended without a last beat");
`endif

endmodule
